// ===== rtl/edd_pkg.sv =====
// edd_pkg: shared types, constants and arithmetic helpers of the error diffusion dither
// used by edd_ram users and error_diffusion_dither; depends on nothing
package edd_pkg;

	localparam int NUM_CH = 3;
	localparam int CHAN_W = 8;
	localparam int ERR_W  = 9;
	localparam int ENTRY_W = NUM_CH * ERR_W;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef chan_t [NUM_CH-1:0] rgb_t;
	typedef logic signed [ERR_W-1:0] err_t;
	typedef err_t [NUM_CH-1:0] err_vec_t;

	// diffusion weights in sixteenths
	typedef logic [2:0] weight_t;
	localparam weight_t W_NONE = 3'd0;
	localparam weight_t W_DIAG_LEFT = 3'd1;
	localparam weight_t W_DIAG_RIGHT = 3'd3;
	localparam weight_t W_ABOVE = 3'd5;
	localparam weight_t W_LEFT = 3'd7;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_QUANT_BITS  = 1'b0,
		CFG_LINE_LENGTH = 1'b1
	} cfg_idx_t;

	localparam logic [3:0] QUANT_BITS_RST = 4'd1;
	localparam logic [12:0] LINE_LENGTH_RST = 13'd1024;

	// v + w/16 * e, floored, clamped to 0..255
	function automatic chan_t add_share(input chan_t v, input weight_t w, input err_t e);
		logic signed [12:0] prod;
		logic signed [13:0] t;
		prod = $signed({1'b0, w}) * $signed({{4{e[ERR_W-1]}}, e});
		t = $signed({2'b00, v, 4'b0000}) + $signed({prod[12], prod});
		if (t[13]) begin
			return 8'd0;
		end else if (t[12:4] > 9'd255) begin
			return 8'hff;
		end else begin
			return t[11:4];
		end
	endfunction

	// spacing of output levels, floor(255 / (2^bits - 1))
	function automatic chan_t quant_level(input logic [3:0] bits);
		case (bits)
			4'd1:    return 8'd255;
			4'd2:    return 8'd85;
			4'd3:    return 8'd36;
			4'd4:    return 8'd17;
			4'd5:    return 8'd8;
			4'd6:    return 8'd4;
			4'd7:    return 8'd2;
			default: return 8'd1;
		endcase
	endfunction

	// bits must already be clamped to 1..8
	function automatic chan_t quantize(input chan_t v, input logic [3:0] bits);
		logic [3:0] sh;
		logic [8:0] bucket_m1;
		logic [8:0] sum;
		logic [8:0] pick;
		logic [7:0] pick_m1;
		logic [15:0] prod;
		sh = 4'd8 - bits;
		bucket_m1 = (9'h100 >> bits) - 9'd1;
		sum = {1'b0, v} + bucket_m1;
		pick = sum >> sh;
		pick_m1 = (pick == 9'd0) ? 8'd0 : 8'(pick - 9'd1);
		prod = 16'(pick_m1) * 16'(quant_level(bits));
		return (prod > 16'd255) ? 8'hff : prod[7:0];
	endfunction

endpackage

// ===== rtl/edd_ram.sv =====
// edd_ram: generic simple dual port ram, one write and one registered read port
// standalone, no package needed
module edd_ram #(
	parameter int DATA_W = 27,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/error_diffusion_dither.sv =====
// error_diffusion_dither: floyd-steinberg error diffusion on an rgba pixel stream
// depends on edd_pkg and edd_ram
//
// usage
//   s_* channel takes one rgba pixel per beat in scan order; s_tuser marks the
//   first pixel of an image and restarts position and history. m_* channel gives
//   the dithered pixel, alpha copied. cfg_* channel writes quant_bits (index 0)
//   and line_length (index 1); write only while no pixel is in flight.
//   throughput: one pixel per clock while m_tready stays high. the left-pixel
//   error loop closes through one stage (last add, quantize, error) and the
//   previous-line errors live in two copies of a line ram so that positions
//   pos and pos+1 are read in the same cycle.
//   pipeline: accept (ram read) -> s1 (earlier-line adds) -> s2 (left add,
//   quantize, ram write) -> output register. pending ram writes are forwarded;
//   a previous-line term coming from the pixel just ahead is applied in s2.
//   reset: position 0, first-line state, errors zero, quant_bits 1,
//   line_length 1024; the line ram is not cleared and needs no sweep.
//   stall: the output register holds while m_tready is low; earlier stages keep
//   filling, so s_tready drops only once all stages are full.
module error_diffusion_dither #(
	parameter int LINE_MAX = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// pixel input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // red_in, green_in, blue_in, alpha_in
	input  logic        s_tuser,   // frame_start
	// pixel output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // red_out, green_out, blue_out, alpha_out
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int PosW = $clog2(LINE_MAX);
	localparam int LenW = $clog2(LINE_MAX + 1);

	// configuration
	logic [3:0]  quant_bits_q;
	logic [12:0] line_length_q;
	logic [3:0]  bits_eff;
	logic [LenW-1:0] len_eff;

	// scan state
	logic [PosW-1:0] pos_q;
	logic            first_q;
	edd_pkg::err_vec_t left_err_q;
	edd_pkg::err_vec_t window_q;

	// accept side
	logic            acc;
	logic [PosW-1:0] pos_a;
	logic            first_a;
	logic [LenW-1:0] pos_inc;
	logic            last_a;
	logic [PosW-1:0] rd1_a;

	// ram
	edd_pkg::err_vec_t rd0_data;
	edd_pkg::err_vec_t rd1_data;
	logic              wr_en;

	// stage 1
	logic              valid_s1;
	edd_pkg::rgb_t     pix_s1;
	edd_pkg::chan_t    alpha_s1;
	logic [PosW-1:0]   pos_s1;
	logic [PosW-1:0]   rd1_s1;
	logic              has1_s1, has5_s1, has3_s1, has7_s1;
	logic              ovr0_s1, ovr1_s1;
	edd_pkg::err_vec_t ovr_d_s1;
	edd_pkg::err_vec_t old0, old1, win_eff;
	logic              def_raw, def5, def3;
	edd_pkg::rgb_t     val_s1;
	edd_pkg::weight_t  late_w;

	// stage 2
	logic              valid_s2;
	edd_pkg::rgb_t     val_s2;
	edd_pkg::chan_t    alpha_s2;
	logic [PosW-1:0]   pos_s2;
	edd_pkg::weight_t  late_w_s2;
	logic              def_raw_s2;
	edd_pkg::err_vec_t old0_s2;
	edd_pkg::rgb_t     q_s2;
	edd_pkg::err_vec_t err_s2;

	// output register
	logic        out_valid_q;
	logic [31:0] out_data_q;

	// flow control
	logic s2_adv, s1_adv;

	assign s2_adv   = !out_valid_q || m_tready;
	assign s1_adv   = !valid_s2 || s2_adv;
	assign s_tready = !valid_s1 || s1_adv;
	assign acc      = s_tvalid && s_tready;
	assign wr_en    = valid_s2 && s2_adv;
	assign cfg_ready = 1'b1;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant_bits_q  <= edd_pkg::QUANT_BITS_RST;
			line_length_q <= edd_pkg::LINE_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				edd_pkg::CFG_QUANT_BITS:  quant_bits_q <= cfg_data[3:0];
				edd_pkg::CFG_LINE_LENGTH: line_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// out-of-range settings act as the nearest legal value
	always_comb begin
		if (quant_bits_q == 4'd0) begin
			bits_eff = 4'd1;
		end else if (quant_bits_q > 4'd8) begin
			bits_eff = 4'd8;
		end else begin
			bits_eff = quant_bits_q;
		end
		if (line_length_q == 13'd0) begin
			len_eff = LenW'(1);
		end else if (32'(line_length_q) > 32'(LINE_MAX)) begin
			len_eff = LenW'(LINE_MAX);
		end else begin
			len_eff = LenW'(line_length_q);
		end
	end

	// position of the incoming pixel and the two line-ram addresses
	always_comb begin
		pos_a   = s_tuser ? '0 : pos_q;
		first_a = s_tuser || first_q;
		pos_inc = LenW'(pos_a) + LenW'(1);
		last_a  = pos_inc >= len_eff;
		rd1_a   = last_a ? pos_a : PosW'(pos_inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			first_q <= 1'b1;
		end else if (acc) begin
			pos_q   <= last_a ? '0 : PosW'(pos_inc);
			first_q <= last_a ? 1'b0 : first_a;
		end
	end

	// two copies of the previous-line errors, written alike, read at pos and pos+1 (pos at line end)
	edd_ram #(
		.DATA_W(edd_pkg::ENTRY_W),
		.DEPTH (LINE_MAX)
	) u_ram_pos (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(pos_s2),
		.wr_data(err_s2),
		.rd_en  (acc),
		.rd_addr(pos_a),
		.rd_data(rd0_data)
	);

	edd_ram #(
		.DATA_W(edd_pkg::ENTRY_W),
		.DEPTH (LINE_MAX)
	) u_ram_next (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(pos_s2),
		.wr_data(err_s2),
		.rd_en  (acc),
		.rd_addr(rd1_a),
		.rd_data(rd1_data)
	);

	// stage 1 capture; a write landing on the same edge as the read is caught here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1   <= s_tdata[23:0];
			alpha_s1 <= s_tdata[31:24];
			pos_s1   <= pos_a;
			rd1_s1   <= rd1_a;
			has1_s1  <= !first_a && (pos_a != '0);
			has5_s1  <= !first_a;
			has3_s1  <= !first_a && !last_a;
			has7_s1  <= pos_a != '0;
			ovr0_s1  <= wr_en && (pos_s2 == pos_a);
			ovr1_s1  <= wr_en && (pos_s2 == rd1_a);
			ovr_d_s1 <= err_s2;
		end
	end

	// stage 1: forwarding and the diagonal and above terms
	always_comb begin
		old0 = ovr0_s1 ? ovr_d_s1 : rd0_data;
		old1 = ovr1_s1 ? ovr_d_s1 : rd1_data;
		// pixel just ahead still in s2 owns the entry: its error arrives in s2
		def_raw = valid_s2 && (pos_s2 == pos_s1);
		def5 = has5_s1 && def_raw;
		def3 = has3_s1 && valid_s2 && (pos_s2 == rd1_s1);
		// window is the entry at pos-1 as the pixel ahead saw it
		if (valid_s2) begin
			win_eff = def_raw_s2 ? left_err_q : old0_s2;
		end else begin
			win_eff = window_q;
		end
		for (int c = 0; c < edd_pkg::NUM_CH; c++) begin
			val_s1[c] = pix_s1[c];
			if (has1_s1) begin
				val_s1[c] = edd_pkg::add_share(val_s1[c], edd_pkg::W_DIAG_LEFT, win_eff[c]);
			end
			if (has5_s1 && !def5) begin
				val_s1[c] = edd_pkg::add_share(val_s1[c], edd_pkg::W_ABOVE, old0[c]);
			end
			if (has3_s1 && !def3) begin
				val_s1[c] = edd_pkg::add_share(val_s1[c], edd_pkg::W_DIAG_RIGHT, old1[c]);
			end
		end
		// the term from the pixel just ahead is always the last one applied
		if (has7_s1) begin
			late_w = edd_pkg::W_LEFT;
		end else if (def5) begin
			late_w = edd_pkg::W_ABOVE;
		end else if (def3) begin
			late_w = edd_pkg::W_DIAG_RIGHT;
		end else begin
			late_w = edd_pkg::W_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			val_s2     <= val_s1;
			alpha_s2   <= alpha_s1;
			pos_s2     <= pos_s1;
			late_w_s2  <= late_w;
			def_raw_s2 <= def_raw;
			old0_s2    <= old0;
		end
	end

	// stage 2: last add from the left error register, quantize, new error
	always_comb begin
		for (int c = 0; c < edd_pkg::NUM_CH; c++) begin
			edd_pkg::chan_t v;
			v = edd_pkg::add_share(val_s2[c], late_w_s2, left_err_q[c]);
			q_s2[c] = edd_pkg::quantize(v, bits_eff);
			err_s2[c] = $signed({1'b0, v}) - $signed({1'b0, q_s2[c]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_err_q <= '0;
			window_q   <= '0;
		end else if (wr_en) begin
			left_err_q <= err_s2;
			window_q   <= def_raw_s2 ? left_err_q : old0_s2;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			out_data_q <= {alpha_s2, q_s2};
		end
	end

endmodule
